// ----- hdl/ncem_pkg.sv -----
// ----------------------------------------------------------------------------
// ncem_pkg
// Shared types and constants of the nearest-centroid electrode map.
// ----------------------------------------------------------------------------
package ncem_pkg;

  localparam int COORD_W   = 24;
  localparam int DIST_W    = 49;
  localparam int THRESH_W  = 50;
  localparam int WCNT_W    = 11;
  localparam int WIDX_W    = 10;
  localparam int EIDX_W    = 6;
  localparam int NUM_EIDX  = 64;
  localparam int RC_W      = 3;
  localparam int CFG_W     = 50;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PKG_LEN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST_SQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIRE_COUNT  = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_QUERY   = 2'd1,
    OP_OFFGRID = 2'd2
  } op_t;

  typedef struct packed {
    logic               req_type;
    logic [WIDX_W-1:0]  wire_index;
    logic [COORD_W-1:0] centroid_x;
    logic [COORD_W-1:0] centroid_y;
    logic [EIDX_W-1:0]  electrode_index;
  } in_item_t;

  typedef struct packed {
    logic [EIDX_W-1:0] queried_electrode;
    logic              connected;
    logic [WIDX_W-1:0] nearest_wire;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [WIDX_W-1:0]  wire_index;
    logic [COORD_W-1:0] centroid_x;
    logic [COORD_W-1:0] centroid_y;
    logic [EIDX_W-1:0]  electrode_index;
    logic [RC_W-1:0]    row;
    logic [RC_W-1:0]    col;
  } cmd_t;

endpackage

// ----- hdl/ncem_ram.sv -----
// ----------------------------------------------------------------------------
// ncem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ncem_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/ncem_front.sv -----
// ----------------------------------------------------------------------------
// ncem_front
// Accepts items, decodes them into commands (grid row and column, range
// checks) and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ncem_front #(
  parameter int GRID_SIDE = 8,
  parameter int MAX_WIRES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ncem_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output ncem_pkg::cmd_t    cmd_item
);
  import ncem_pkg::*;

  localparam int CELLS = GRID_SIDE * GRID_SIDE;

  function automatic logic [NUM_EIDX*RC_W-1:0] build_tab(input logic want_col);
    logic [NUM_EIDX*RC_W-1:0] t;
    t = '0;
    for (int k = 0; k < NUM_EIDX; k++) begin
      t[k*RC_W +: RC_W] = want_col ? RC_W'(k % GRID_SIDE) : RC_W'(k / GRID_SIDE);
    end
    return t;
  endfunction

  localparam logic [NUM_EIDX*RC_W-1:0] ROW_TAB = build_tab(1'b0);
  localparam logic [NUM_EIDX*RC_W-1:0] COL_TAB = build_tab(1'b1);

  cmd_t       dec;
  logic       keep;
  logic       push;
  logic       pop;
  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    dec.wire_index      = in_data.wire_index;
    dec.centroid_x      = in_data.centroid_x;
    dec.centroid_y      = in_data.centroid_y;
    dec.electrode_index = in_data.electrode_index;
    dec.row             = ROW_TAB[in_data.electrode_index*RC_W +: RC_W];
    dec.col             = COL_TAB[in_data.electrode_index*RC_W +: RC_W];
    keep                = 1'b1;
    if (in_data.req_type == REQ_LOAD) begin
      dec.op = OP_LOAD;
      keep   = {1'b0, in_data.wire_index} < WCNT_W'(MAX_WIRES);
    end else if ({1'b0, in_data.electrode_index} < (EIDX_W+1)'(CELLS)) begin
      dec.op = OP_QUERY;
    end else begin
      dec.op = OP_OFFGRID;
    end
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ----- hdl/ncem_back.sv -----
// ----------------------------------------------------------------------------
// ncem_back
// Executes commands: writes centroids, places the electrode with a reciprocal
// multiply and scans the centroid store through a four-stage distance pipe.
// ----------------------------------------------------------------------------
module ncem_back #(
  parameter int GRID_SIDE = 8,
  parameter int MAX_WIRES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cmd_valid,
  output logic                                  cmd_ready,
  input  ncem_pkg::cmd_t                        cmd_item,
  input  logic [ncem_pkg::COORD_W-1:0]          pkg_len,
  input  logic [ncem_pkg::THRESH_W-1:0]         max_distance_sq,
  input  logic [ncem_pkg::WCNT_W-1:0]           wire_count,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ncem_pkg::out_item_t                   out_data
);
  import ncem_pkg::*;

  localparam int DEN    = 2 * GRID_SIDE;
  localparam int ODD_W  = $clog2(DEN);
  localparam int NUM_W  = COORD_W + ODD_W;
  localparam int SH     = NUM_W + ODD_W;
  localparam int RCP_W  = NUM_W + 1;
  localparam int PROD_W = NUM_W + RCP_W;
  localparam int AW     = (MAX_WIRES > 1) ? $clog2(MAX_WIRES) : 1;
  localparam int CW     = $clog2(MAX_WIRES + 1);
  localparam int SQ_W   = 2 * COORD_W;

  // ceil(2^SH / DEN): exact floor division for any numerator below 2^NUM_W
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN));

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic               pop;
  logic [ODD_W-1:0]   odd_x, odd_y;
  logic [NUM_W-1:0]   numx_r, numy_r;
  logic [PROD_W-1:0]  prodx, prody;
  logic [CW-1:0]      n_r;
  logic [CW-1:0]      issue_cnt_r;
  logic               issue;
  logic [EIDX_W-1:0]  k_r;
  logic [COORD_W-1:0] ex_r, ey_r;

  logic               wr_en;
  logic [2*COORD_W-1:0] rd_data;

  logic               p0_v_r, p1_v_r, p2_v_r, p3_v_r;
  logic [AW-1:0]      p0_w_r, p1_w_r, p2_w_r, p3_w_r;
  logic [COORD_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r;
  logic [DIST_W-1:0]  dist_r;
  logic               better;

  logic               found_r;
  logic [DIST_W-1:0]  best_r;
  logic [AW-1:0]      best_w_r;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;
  logic               out_load;

  assign cmd_ready = (state_r == S_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign wr_en     = pop && (cmd_item.op == OP_LOAD);

  assign odd_x = ODD_W'({cmd_item.row, 1'b1});
  assign odd_y = ODD_W'({cmd_item.col, 1'b1});

  assign prodx = PROD_W'(numx_r) * PROD_W'(RECIP);
  assign prody = PROD_W'(numy_r) * PROD_W'(RECIP);

  assign issue  = (state_r == S_SCAN) && (issue_cnt_r != n_r);
  assign better = p3_v_r && (!found_r || dist_r < best_r) &&
                  ({1'b0, dist_r} < max_distance_sq);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  ncem_ram #(
    .WIDTH (2*COORD_W),
    .DEPTH (MAX_WIRES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cmd_item.wire_index[AW-1:0]),
    .wr_data ({cmd_item.centroid_x, cmd_item.centroid_y}),
    .rd_en   (issue),
    .rd_addr (issue_cnt_r[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_item.op)
            OP_QUERY:   state_nxt = S_DIV;
            OP_OFFGRID: state_nxt = S_DONE;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (!issue && !p0_v_r && !p1_v_r && !p2_v_r && !p3_v_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p0_v_r      <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      p0_v_r      <= issue;
      p1_v_r      <= p0_v_r;
      p2_v_r      <= p1_v_r;
      p3_v_r      <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      numx_r    <= NUM_W'(pkg_len) * NUM_W'(odd_x);
      numy_r    <= NUM_W'(pkg_len) * NUM_W'(odd_y);
      k_r       <= cmd_item.electrode_index;
      n_r       <= (wire_count > WCNT_W'(MAX_WIRES)) ? CW'(MAX_WIRES) : CW'(wire_count);
      found_r   <= 1'b0;
      best_r    <= '0;
      best_w_r  <= '0;
    end else if (state_r == S_DIV) begin
      ex_r        <= prodx[SH +: COORD_W];
      ey_r        <= prody[SH +: COORD_W];
      issue_cnt_r <= '0;
    end else begin
      if (issue) begin
        issue_cnt_r <= issue_cnt_r + CW'(1);
      end
      if (better) begin
        found_r  <= 1'b1;
        best_r   <= dist_r;
        best_w_r <= p3_w_r;
      end
    end
  end

  // distance pipe: read -> |diff| -> square -> sum -> compare
  always_ff @(posedge clk) begin
    p0_w_r <= issue_cnt_r[AW-1:0];
    p1_w_r <= p0_w_r;
    p2_w_r <= p1_w_r;
    p3_w_r <= p2_w_r;
    dx_r   <= (ex_r >= rd_data[2*COORD_W-1:COORD_W]) ?
              ex_r - rd_data[2*COORD_W-1:COORD_W] : rd_data[2*COORD_W-1:COORD_W] - ex_r;
    dy_r   <= (ey_r >= rd_data[COORD_W-1:0]) ?
              ey_r - rd_data[COORD_W-1:0] : rd_data[COORD_W-1:0] - ey_r;
    sqx_r  <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r  <= SQ_W'(dy_r) * SQ_W'(dy_r);
    dist_r <= DIST_W'(sqx_r) + DIST_W'(sqy_r);
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.queried_electrode <= k_r;
      out_data_r.connected         <= found_r;
      out_data_r.nearest_wire      <= found_r ? WIDX_W'(best_w_r) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/nearest_centroid_electrode_map.sv -----
// ----------------------------------------------------------------------------
// nearest_centroid_electrode_map
// Maps grid electrodes to the nearest loaded wire centroid below a squared
// distance threshold.
//
//   port group | handshake           | payload
//   -----------+---------------------+--------------------------------
//   in_        | in_valid/in_ready   | in_data  (load or query item)
//   out_       | out_valid/out_ready | out_data (one per query item)
//   cfg_       | cfg_we              | cfg_index, cfg_data
//
// A load item is taken by the back end without leaving its idle state; an
// off-grid query passes through its done state only. A query on the grid
// holds it for the pop, one reciprocal-multiply placement step, one centroid
// RAM read per wire (min(wire_count, MAX_WIRES) wires), pipe fill and drain,
// and the output load, which waits while the output register is full.
// A two-entry queue keeps accepting items while a scan runs, until it is
// full; the output register holds a result until taken. Reset is
// synchronous; the centroid RAM is not cleared.
// ----------------------------------------------------------------------------
module nearest_centroid_electrode_map #(
  parameter int GRID_SIDE = 8,
  parameter int MAX_WIRES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ncem_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ncem_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ncem_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ncem_pkg::CFG_W-1:0]          cfg_data
);
  import ncem_pkg::*;

  logic [COORD_W-1:0]  pkg_len_r;
  logic [THRESH_W-1:0] max_distance_sq_r;
  logic [WCNT_W-1:0]   wire_count_r;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkg_len_r         <= '0;
      max_distance_sq_r <= '0;
      wire_count_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PKG_LEN:     pkg_len_r         <= cfg_data[COORD_W-1:0];
        CFG_MAX_DIST_SQ: max_distance_sq_r <= cfg_data[THRESH_W-1:0];
        CFG_WIRE_COUNT:  wire_count_r      <= cfg_data[WCNT_W-1:0];
        default: ;
      endcase
    end
  end

  ncem_front #(
    .GRID_SIDE (GRID_SIDE),
    .MAX_WIRES (MAX_WIRES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item)
  );

  ncem_back #(
    .GRID_SIDE (GRID_SIDE),
    .MAX_WIRES (MAX_WIRES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd_item        (cmd_item),
    .pkg_len         (pkg_len_r),
    .max_distance_sq (max_distance_sq_r),
    .wire_count      (wire_count_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

endmodule

// ----- hdl/ncem_checker.sv -----
// ----------------------------------------------------------------------------
// ncem_checker
// Port-level checks of the electrode map, bound to the top level.
// ----------------------------------------------------------------------------
module ncem_checker #(
  parameter int GRID_SIDE = 8
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input ncem_pkg::out_item_t out_data
);
  import ncem_pkg::*;

  localparam int CELLS = GRID_SIDE * GRID_SIDE;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_unconn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.connected |-> out_data.nearest_wire == '0)
    else $error("unconnected item carries a wire index");

  a_conn_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.connected |->
      {1'b0, out_data.queried_electrode} < (EIDX_W+1)'(CELLS))
    else $error("off-grid electrode reported connected");

endmodule

bind nearest_centroid_electrode_map ncem_checker #(
  .GRID_SIDE (GRID_SIDE)
) u_ncem_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
